@@ hw/rtl/lkn_pkg.sv @@
// shared types and constants for the keyed name cache
package lkn_pkg;

  localparam int unsigned KCNT_W = 9;
  localparam int unsigned NCNT_W = 6;
  localparam int unsigned CAP_W  = 6;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd33;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_FILL   = 2'd1;
  localparam logic [1:0] MODE_FAIL   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] ST_FALLBACK = 2'd0;
  localparam logic [1:0] ST_REQUEST  = 2'd1;
  localparam logic [1:0] ST_NATIVE   = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [KCNT_W-1:0] kcnt;
    logic [NCNT_W-1:0] ncnt;
    logic              ovf;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ENT, S_KRD, S_KCMP, S_DECIDE, S_CKRD, S_CKWR, S_NRD, S_NWR
  } state_e;

endpackage

@@ hw/rtl/lkn_ram.sv @@
// generic single write port ram with registered read
module lkn_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 64
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  waddr_i,
  input  logic [W-1:0]                        wdata_i,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  raddr_i,
  output logic [W-1:0]                        rdata_o
);
  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hw/rtl/lkn_front.sv @@
// front end: collects key and name characters and queues the closing command
module lkn_front import lkn_pkg::*; #(
  parameter int unsigned KEY_MAX  = 64,
  parameter int unsigned NAME_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  mode_i,
  input  logic        part_i,
  input  logic        has_char_i,
  input  logic [7:0]  char_value_i,
  input  logic        end_of_request_i,
  input  logic        pop_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  output logic        pk_we_o,
  output logic [(KEY_MAX > 1 ? $clog2(KEY_MAX) : 1)-1:0]   pk_waddr_o,
  output logic        pn_we_o,
  output logic [(NAME_MAX > 1 ? $clog2(NAME_MAX) : 1)-1:0] pn_waddr_o
);
  localparam int unsigned KCW = $clog2(KEY_MAX + 1);
  localparam int unsigned NCW = $clog2(NAME_MAX + 1);
  localparam int unsigned KIW = KEY_MAX > 1 ? $clog2(KEY_MAX) : 1;
  localparam int unsigned NIW = NAME_MAX > 1 ? $clog2(NAME_MAX) : 1;

  logic [KCW-1:0] kcnt_q, kcnt_d;
  logic [NCW-1:0] ncnt_q, ncnt_d;
  logic           ovf_q, ovf_d;
  logic           cv_q, cv_d;
  cmd_t           cmd_q, cmd_d;
  logic           is_char;

  assign is_char    = accept_i && has_char_i && (char_value_i != 8'd0);
  assign pk_waddr_o = kcnt_q[KIW-1:0];
  assign pn_waddr_o = ncnt_q[NIW-1:0];
  assign pk_we_o    = is_char && !part_i && (kcnt_q < KCW'(KEY_MAX));
  assign pn_we_o    = is_char && part_i && (ncnt_q < NCW'(NAME_MAX));
  assign cmd_valid_o = cv_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    kcnt_d = kcnt_q;
    ncnt_d = ncnt_q;
    ovf_d  = ovf_q;
    cv_d   = cv_q && !pop_i;
    cmd_d  = cmd_q;
    if (pk_we_o) begin
      kcnt_d = kcnt_q + KCW'(1);
    end
    if (pn_we_o) begin
      ncnt_d = ncnt_q + NCW'(1);
    end
    if (is_char && !pk_we_o && !pn_we_o) begin
      ovf_d = 1'b1;
    end
    if (accept_i && end_of_request_i) begin
      cv_d       = 1'b1;
      cmd_d.mode = mode_i;
      cmd_d.kcnt = KCNT_W'(kcnt_d);
      cmd_d.ncnt = NCNT_W'(ncnt_d);
      cmd_d.ovf  = ovf_d;
      kcnt_d     = '0;
      ncnt_d     = '0;
      ovf_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcnt_q <= '0;
      ncnt_q <= '0;
      ovf_q  <= 1'b0;
      cv_q   <= 1'b0;
    end else begin
      kcnt_q <= kcnt_d;
      ncnt_q <= ncnt_d;
      ovf_q  <= ovf_d;
      cv_q   <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end
endmodule

@@ hw/rtl/lkn_back.sv @@
// back end: entry search, replacement, store update and result sequencing
module lkn_back import lkn_pkg::*; #(
  parameter int unsigned ENTRIES  = 8,
  parameter int unsigned KEY_MAX  = 64,
  parameter int unsigned NAME_MAX = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CAP_W-1:0]  cap_i,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  output logic              busy_o,
  output logic [(KEY_MAX > 1 ? $clog2(KEY_MAX) : 1)-1:0]   pk_raddr_o,
  input  logic [7:0]        pk_rdata_i,
  output logic [(NAME_MAX > 1 ? $clog2(NAME_MAX) : 1)-1:0] pn_raddr_o,
  input  logic [7:0]        pn_rdata_i,
  output logic              strobe_o,
  output logic [1:0]        status_o,
  output logic              byte_valid_o,
  output logic [7:0]        name_byte_o,
  output logic              last_of_run_o
);
  localparam int unsigned KCW = $clog2(KEY_MAX + 1);
  localparam int unsigned NCW = $clog2(NAME_MAX + 1);
  localparam int unsigned JW  = KCW > NCW ? KCW : NCW;
  localparam int unsigned KIW = KEY_MAX > 1 ? $clog2(KEY_MAX) : 1;
  localparam int unsigned NIW = NAME_MAX > 1 ? $clog2(NAME_MAX) : 1;
  localparam int unsigned ECW = $clog2(ENTRIES + 1);
  localparam int unsigned EIW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int unsigned KSD = ENTRIES * KEY_MAX;
  localparam int unsigned NSD = ENTRIES * NAME_MAX;
  localparam int unsigned KAW = KSD > 1 ? $clog2(KSD) : 1;
  localparam int unsigned NAW = NSD > 1 ? $clog2(NSD) : 1;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  logic [ECW-1:0] e_q, e_d;
  logic [JW-1:0]  j_q, j_d;
  logic           hit_q, hit_d, free_q, free_d;
  logic [EIW-1:0] hit_e_q, hit_e_d, free_e_q, free_e_d, best_e_q, best_e_d, tgt_q, tgt_d;
  logic [31:0]    best_age_q, best_age_d, ctr_q, ctr_d;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [31:0]        age_q [ENTRIES];
  logic [31:0]        age_d [ENTRIES];
  logic [KCW-1:0]     klen_q [ENTRIES];
  logic [KCW-1:0]     klen_d [ENTRIES];
  logic [NCW-1:0]     nlen_q [ENTRIES];
  logic [NCW-1:0]     nlen_d [ENTRIES];

  logic       st_q, st_d, bv_q, bv_d, last_q, last_d;
  logic [1:0] status_q, status_d;
  logic [7:0] byte_q, byte_d;

  logic [EIW-1:0] ei;
  logic [KCW-1:0] kcnt;
  logic [NCW-1:0] ncnt, len;
  logic           key_ok, is_fill;
  logic           ks_we, ns_we;
  logic [KAW-1:0] ks_addr;
  logic [NAW-1:0] ns_addr;
  logic [7:0]     ks_rdata, ns_rdata;
  logic [EIW-1:0] ks_e, ns_e;

  assign ei      = e_q[EIW-1:0];
  assign kcnt    = KCW'(cmd_q.kcnt);
  assign ncnt    = NCW'(cmd_q.ncnt);
  assign is_fill = (cmd_q.mode == MODE_FILL);
  assign len     = is_fill ? ncnt : nlen_q[tgt_q];
  assign pk_raddr_o = j_q[KIW-1:0];
  assign pn_raddr_o = j_q[NIW-1:0];
  assign ks_e    = (state_q == S_CKWR) ? tgt_q : ei;
  assign ks_addr = KAW'(ks_e) * KAW'(KEY_MAX) + KAW'(j_q[KIW-1:0]);
  assign ns_e    = tgt_q;
  assign ns_addr = NAW'(ns_e) * NAW'(NAME_MAX) + NAW'(j_q[NIW-1:0]);
  assign ks_we   = (state_q == S_CKWR);
  assign ns_we   = (state_q == S_NWR) && is_fill;

  lkn_ram #(.W(8), .D(KSD)) u_key_store (
    .clk_i, .we_i(ks_we), .waddr_i(ks_addr), .wdata_i(pk_rdata_i),
    .raddr_i(ks_addr), .rdata_o(ks_rdata)
  );

  lkn_ram #(.W(8), .D(NSD)) u_name_store (
    .clk_i, .we_i(ns_we), .waddr_i(ns_addr), .wdata_i(pn_rdata_i),
    .raddr_i(ns_addr), .rdata_o(ns_rdata)
  );

  assign busy_o        = (state_q != S_IDLE);
  assign strobe_o      = st_q;
  assign status_o      = status_q;
  assign byte_valid_o  = bv_q;
  assign name_byte_o   = byte_q;
  assign last_of_run_o = last_q;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    e_d        = e_q;
    j_d        = j_q;
    hit_d      = hit_q;
    hit_e_d    = hit_e_q;
    free_d     = free_q;
    free_e_d   = free_e_q;
    best_e_d   = best_e_q;
    best_age_d = best_age_q;
    tgt_d      = tgt_q;
    ctr_d      = ctr_q;
    valid_d    = valid_q;
    age_d      = age_q;
    klen_d     = klen_q;
    nlen_d     = nlen_q;
    pop_o      = 1'b0;
    st_d       = 1'b0;
    bv_d       = 1'b0;
    last_d     = 1'b0;
    status_d   = ST_FALLBACK;
    byte_d     = 8'd0;
    key_ok     = (cmd_i.kcnt != '0) && !cmd_i.ovf && (cap_i != '0);
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o      = 1'b1;
          cmd_d      = cmd_i;
          e_d        = '0;
          hit_d      = 1'b0;
          free_d     = 1'b0;
          best_e_d   = '0;
          best_age_d = '1;
          if ((cmd_i.mode == MODE_LOOKUP && key_ok) ||
              (cmd_i.mode == MODE_FILL && key_ok && cmd_i.ncnt != '0 &&
               {1'b0, cmd_i.ncnt} < {1'b0, cap_i})) begin
            state_d = S_ENT;
          end else begin
            st_d   = 1'b1;
            last_d = 1'b1;
          end
        end
      end
      S_ENT: begin
        if (e_q == ECW'(ENTRIES)) begin
          state_d = S_DECIDE;
        end else begin
          if (!valid_q[ei] && !free_q) begin
            free_d   = 1'b1;
            free_e_d = ei;
          end
          if (age_q[ei] < best_age_q) begin
            best_age_d = age_q[ei];
            best_e_d   = ei;
          end
          if (valid_q[ei] && klen_q[ei] == kcnt) begin
            j_d     = '0;
            state_d = S_KRD;
          end else begin
            e_d = e_q + ECW'(1);
          end
        end
      end
      S_KRD: begin
        state_d = S_KCMP;
      end
      S_KCMP: begin
        if (ks_rdata != pk_rdata_i) begin
          e_d     = e_q + ECW'(1);
          state_d = S_ENT;
        end else if (j_q + JW'(1) == JW'(kcnt)) begin
          hit_d   = 1'b1;
          hit_e_d = ei;
          state_d = S_DECIDE;
        end else begin
          j_d     = j_q + JW'(1);
          state_d = S_KRD;
        end
      end
      S_DECIDE: begin
        st_d    = 1'b1;
        j_d     = '0;
        state_d = S_IDLE;
        if (!is_fill) begin
          if (!hit_q) begin
            status_d = ST_REQUEST;
            last_d   = 1'b1;
          end else if ({1'b0, nlen_q[hit_e_q]} >= 7'(cap_i)) begin
            last_d = 1'b1;
          end else begin
            ctr_d          = ctr_q + 32'd1;
            age_d[hit_e_q] = ctr_q + 32'd1;
            tgt_d          = hit_e_q;
            status_d       = ST_NATIVE;
            last_d         = (nlen_q[hit_e_q] == '0);
            if (nlen_q[hit_e_q] != '0) begin
              state_d = S_NRD;
            end
          end
        end else begin
          tgt_d = hit_q ? hit_e_q : (free_q ? free_e_q : best_e_q);
          valid_d[tgt_d] = 1'b1;
          ctr_d          = ctr_q + 32'd1;
          age_d[tgt_d]   = ctr_q + 32'd1;
          klen_d[tgt_d]  = kcnt;
          nlen_d[tgt_d]  = ncnt;
          status_d       = ST_NATIVE;
          state_d        = S_CKRD;
        end
      end
      S_CKRD: begin
        state_d = S_CKWR;
      end
      S_CKWR: begin
        if (j_q + JW'(1) == JW'(kcnt)) begin
          j_d     = '0;
          state_d = S_NRD;
        end else begin
          j_d     = j_q + JW'(1);
          state_d = S_CKRD;
        end
      end
      S_NRD: begin
        state_d = S_NWR;
      end
      S_NWR: begin
        st_d     = 1'b1;
        bv_d     = 1'b1;
        status_d = ST_NATIVE;
        byte_d   = is_fill ? pn_rdata_i : ns_rdata;
        last_d   = (j_q + JW'(1) == JW'(len));
        if (last_d) begin
          state_d = S_IDLE;
        end else begin
          j_d     = j_q + JW'(1);
          state_d = S_NRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      ctr_q   <= '0;
      st_q    <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      ctr_q   <= ctr_d;
      st_q    <= st_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    e_q        <= e_d;
    j_q        <= j_d;
    hit_q      <= hit_d;
    hit_e_q    <= hit_e_d;
    free_q     <= free_d;
    free_e_q   <= free_e_d;
    best_e_q   <= best_e_d;
    best_age_q <= best_age_d;
    tgt_q      <= tgt_d;
    klen_q     <= klen_d;
    nlen_q     <= nlen_d;
    bv_q       <= bv_d;
    last_q     <= last_d;
    status_q   <= status_d;
    byte_q     <= byte_d;
  end
endmodule

@@ hw/rtl/lru_keyed_name_cache.sv @@
// top level of the keyed name cache
// Usage: an item (one key or name character, or an empty marker) is taken at a
// clock edge where start is high and busy is low. The item with end_of_request_i
// set closes the request; busy rises on the next cycle and falls in the cycle
// that carries the last result, so the next item can be taken at the edge that
// ends that result.
// Results come out on strobe, one per cycle at most, each valid for exactly one
// cycle; the receiver cannot stall, so no result is ever held back.
// Character items can be taken back to back, one per cycle while busy is low.
// After a closing item a request refused before the search gets its status
// result from the idle state; else it follows the entry scan, key byte compares
// and the decision. Each name byte is then read and sent; a fill first copies
// the key byte by byte. The status result comes first, name bytes after it,
// last_of_run_o on the last. The capacity register is written through
// cfg_we_i / cfg_wdata_i; the user must do so only while idle, which the block
// does not enforce. Reset clears all entries, ages, the use counter and the
// pending counts and sets the capacity to 33; the stores need no clearing.
module lru_keyed_name_cache import lkn_pkg::*; #(
  parameter int unsigned ENTRIES  = 8,
  parameter int unsigned KEY_MAX  = 64,
  parameter int unsigned NAME_MAX = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       mode_i,
  input  logic             part_i,
  input  logic             has_char_i,
  input  logic [7:0]       char_value_i,
  input  logic             end_of_request_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  output logic             strobe,
  output logic [1:0]       status_o,
  output logic             byte_valid_o,
  output logic [7:0]       name_byte_o,
  output logic             last_of_run_o
);
  localparam int unsigned KIW = KEY_MAX > 1 ? $clog2(KEY_MAX) : 1;
  localparam int unsigned NIW = NAME_MAX > 1 ? $clog2(NAME_MAX) : 1;

  logic [CAP_W-1:0] cap_q;
  logic             accept, pop, cmd_valid, back_busy;
  cmd_t             cmd;
  logic             pk_we, pn_we;
  logic [KIW-1:0]   pk_waddr, pk_raddr;
  logic [NIW-1:0]   pn_waddr, pn_raddr;
  logic [7:0]       pk_rdata, pn_rdata;

  assign busy   = cmd_valid || back_busy;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  lkn_front #(.KEY_MAX(KEY_MAX), .NAME_MAX(NAME_MAX)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .mode_i, .part_i, .has_char_i,
    .char_value_i, .end_of_request_i, .pop_i(pop), .cmd_valid_o(cmd_valid),
    .cmd_o(cmd), .pk_we_o(pk_we), .pk_waddr_o(pk_waddr), .pn_we_o(pn_we),
    .pn_waddr_o(pn_waddr)
  );

  // pending key and name buffers
  lkn_ram #(.W(8), .D(KEY_MAX)) u_pend_key (
    .clk_i, .we_i(pk_we), .waddr_i(pk_waddr), .wdata_i(char_value_i),
    .raddr_i(pk_raddr), .rdata_o(pk_rdata)
  );

  lkn_ram #(.W(8), .D(NAME_MAX)) u_pend_name (
    .clk_i, .we_i(pn_we), .waddr_i(pn_waddr), .wdata_i(char_value_i),
    .raddr_i(pn_raddr), .rdata_o(pn_rdata)
  );

  lkn_back #(.ENTRIES(ENTRIES), .KEY_MAX(KEY_MAX), .NAME_MAX(NAME_MAX)) u_back (
    .clk_i, .rst_ni, .cap_i(cap_q), .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .pop_o(pop), .busy_o(back_busy), .pk_raddr_o(pk_raddr), .pk_rdata_i(pk_rdata),
    .pn_raddr_o(pn_raddr), .pn_rdata_i(pn_rdata), .strobe_o(strobe),
    .status_o, .byte_valid_o, .name_byte_o, .last_of_run_o
  );
endmodule
